FILE: src/radar_target_frame_parser_defines.svh
// assertion macros for the radar target frame parser
`ifndef RADAR_TARGET_FRAME_PARSER_DEFINES_SVH
`define RADAR_TARGET_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define RTFP_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rtfp assertion failed");
// next-cycle implication, sampled on clk_i, off during reset
`define RTFP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rtfp assertion failed");
`else
`define RTFP_ASSERT_NOW(name, pre, post)
`define RTFP_ASSERT_NEXT(name, pre, post)
`endif

`endif

FILE: src/rtfp_pkg.sv
// shared types and constants for the radar target frame parser
package rtfp_pkg;

  // frame header bytes
  localparam logic [7:0] Sync0 = 8'hF4;
  localparam logic [7:0] Sync1 = 8'hF3;
  localparam logic [7:0] Sync2 = 8'hF2;
  localparam logic [7:0] Sync3 = 8'hF1;

  // accepted frame length range
  localparam logic [7:0] LenMin = 8'd7;
  localparam logic [7:0] LenMax = 8'd64;

  // bytes after the length field beyond the payload length (type, head, footer)
  localparam logic [6:0] FrameExtra = 7'd4;

  // report frame identifiers
  localparam logic [7:0] TypeReport = 8'h02;
  localparam logic [7:0] HeadReport = 8'hAA;

  // byte positions inside a report frame, counted after the length field
  localparam logic [6:0] PosFlags   = 7'd2;
  localparam logic [6:0] PosMoveLo  = 7'd3;
  localparam logic [6:0] PosMoveHi  = 7'd4;
  localparam logic [6:0] PosStillLo = 7'd6;
  localparam logic [6:0] PosStillHi = 7'd7;

  // presence codes
  localparam logic [1:0] PresNone   = 2'd0;
  localparam logic [1:0] PresMoving = 2'd1;
  localparam logic [1:0] PresStill  = 2'd2;

  // mid queue depth
  localparam int unsigned MidDepth = 2;

  // parser phases
  typedef enum logic [6:0] {
    PhHunt   = 7'b000_0001,
    PhLenLo  = 7'b000_0010,
    PhLenHi  = 7'b000_0100,
    PhType   = 7'b000_1000,
    PhHeadOk = 7'b001_0000,
    PhSkip   = 7'b010_0000,
    PhReport = 7'b100_0000
  } phase_e;

  // raw captures of one report frame
  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] moving;
    logic [15:0] still;
  } frame_t;

  // header byte expected at a given match position
  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] res;
    unique case (idx)
      2'd0:    res = Sync0;
      2'd1:    res = Sync1;
      2'd2:    res = Sync2;
      default: res = Sync3;
    endcase
    return res;
  endfunction

endpackage

FILE: src/rtfp_front.sv
// front end: byte-wise frame parser that captures report fields
module rtfp_front import rtfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       frame_valid_o,
  output frame_t     frame_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [6:0]  pay_len_q, pay_len_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] mv_q, mv_d;
  logic [15:0] st_q, st_d;

  logic [6:0] cnt_inc;
  logic       frame_end;
  logic       len_ok;

  assign cnt_inc   = cnt_q + 7'd1;
  assign frame_end = (cnt_inc >= (pay_len_q + FrameExtra));
  assign len_ok    = (rx_byte_i == 8'd0) && (len_lo_q >= LenMin) && (len_lo_q <= LenMax);

  // next-state and capture logic
  always_comb begin
    phase_d       = phase_q;
    hdr_idx_d     = hdr_idx_q;
    len_lo_d      = len_lo_q;
    pay_len_d     = pay_len_q;
    cnt_d         = cnt_q;
    flags_d       = flags_q;
    mv_d          = mv_q;
    st_d          = st_q;
    frame_valid_o = 1'b0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == sync_byte(hdr_idx_q)) begin
            if (hdr_idx_q == 2'd3) begin
              hdr_idx_d = 2'd0;
              phase_d   = PhLenLo;
            end else begin
              hdr_idx_d = hdr_idx_q + 2'd1;
            end
          end else begin
            hdr_idx_d = 2'd0;
          end
        end
        PhLenLo: begin
          len_lo_d = rx_byte_i;
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          if (len_ok) begin
            pay_len_d = len_lo_q[6:0];
            cnt_d     = 7'd0;
            phase_d   = PhType;
          end else begin
            hdr_idx_d = 2'd0;
            phase_d   = PhHunt;
          end
        end
        PhType: begin
          cnt_d   = 7'd1;
          phase_d = (rx_byte_i == TypeReport) ? PhHeadOk : PhSkip;
        end
        PhHeadOk: begin
          cnt_d   = 7'd2;
          phase_d = (rx_byte_i == HeadReport) ? PhReport : PhSkip;
        end
        PhSkip: begin
          cnt_d = cnt_inc;
          if (frame_end) begin
            hdr_idx_d = 2'd0;
            phase_d   = PhHunt;
          end
        end
        PhReport: begin
          if (cnt_q == PosFlags) begin
            flags_d = rx_byte_i;
          end else if (cnt_q == PosMoveLo) begin
            mv_d = {8'd0, rx_byte_i};
          end else if (cnt_q == PosMoveHi) begin
            mv_d = {rx_byte_i, mv_q[7:0]};
          end else if (cnt_q == PosStillLo) begin
            st_d = {8'd0, rx_byte_i};
          end else if (cnt_q == PosStillHi) begin
            st_d = {rx_byte_i, st_q[7:0]};
          end
          cnt_d = cnt_inc;
          if (frame_end) begin
            hdr_idx_d     = 2'd0;
            phase_d       = PhHunt;
            frame_valid_o = 1'b1;
          end
        end
        default: begin
          hdr_idx_d = 2'd0;
          phase_d   = PhHunt;
        end
      endcase
    end
  end

  assign frame_o = '{flags: flags_d, moving: mv_d, still: st_d};

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      hdr_idx_q <= 2'd0;
      len_lo_q  <= 8'd0;
      pay_len_q <= 7'd0;
      cnt_q     <= 7'd0;
      flags_q   <= 8'd0;
      mv_q      <= 16'd0;
      st_q      <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      len_lo_q  <= len_lo_d;
      pay_len_q <= pay_len_d;
      cnt_q     <= cnt_d;
      flags_q   <= flags_d;
      mv_q      <= mv_d;
      st_q      <= st_d;
    end
  end

endmodule

FILE: src/rtfp_fifo.sv
// short queue of captured frames between front and back end
module rtfp_fifo import rtfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_req_i,
  input  frame_t push_data_i,
  output logic   full_o,
  input  logic   pop_req_i,
  output logic   empty_o,
  output frame_t pop_data_o
);

  localparam int unsigned PtrW = (MidDepth > 1) ? $clog2(MidDepth) : 1;
  localparam int unsigned CntW = $clog2(MidDepth + 1);

  frame_t            mem_q [MidDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(MidDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_req_i && !full_o;
  assign do_pop     = pop_req_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(MidDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(MidDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: src/rtfp_back.sv
// back end: turns captured frames into readings and holds the result
module rtfp_back import rtfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        frame_avail_i,
  input  frame_t      frame_i,
  output logic        frame_take_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        reading_valid_o,
  output logic        motion_seen_o,
  output logic [1:0]  target_total_o,
  output logic [1:0]  presence_kind_o,
  output logic [15:0] nearest_cm_o
);

  logic        out_valid_q;
  logic        valid_q, motion_q;
  logic [1:0]  total_q, kind_q;
  logic [15:0] near_q;

  logic        mv_bit, st_bit;
  logic        valid_d;
  logic [1:0]  total_d, kind_d;
  logic [15:0] near_d;

  assign frame_take_o = frame_avail_i && (!out_valid_q || pop_i);

  // reading from the state byte and distances
  always_comb begin
    mv_bit  = frame_i.flags[0];
    st_bit  = frame_i.flags[1];
    valid_d = !((frame_i.flags != 8'd0) && !mv_bit && !st_bit);
    total_d = {1'b0, mv_bit} + {1'b0, st_bit};
    if (mv_bit) begin
      kind_d = PresMoving;
    end else if (st_bit) begin
      kind_d = PresStill;
    end else begin
      kind_d = PresNone;
    end
    if (mv_bit && st_bit) begin
      near_d = (frame_i.still < frame_i.moving) ? frame_i.still : frame_i.moving;
    end else if (mv_bit) begin
      near_d = frame_i.moving;
    end else if (st_bit) begin
      near_d = frame_i.still;
    end else begin
      near_d = 16'd0;
    end
  end

  // output register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (frame_take_o) begin
      valid_q  <= valid_d;
      motion_q <= frame_i.flags[0];
      total_q  <= total_d;
      kind_q   <= kind_d;
      near_q   <= near_d;
    end
  end

  assign empty_o         = !out_valid_q;
  assign reading_valid_o = valid_q;
  assign motion_seen_o   = motion_q;
  assign target_total_o  = total_q;
  assign presence_kind_o = kind_q;
  assign nearest_cm_o    = near_q;

endmodule

FILE: src/radar_target_frame_parser.sv
// Radar target frame parser: takes one serial byte per request (push/full) and
// recovers report frames F4 F3 F2 F1, little-endian length (7..64), type 02,
// head AA, data, footer; other frames are skipped whole and the footer is not
// checked. Each report frame yields one reading (pop/empty) on its last byte:
// validity, motion, target count, presence kind and nearest distance in cm.
// A byte is taken every cycle while full is low; full rises only while the
// two-entry frame queue between the parser and the result register is full,
// i.e. when readings are not being popped. After the last byte of its frame,
// a reading goes into the frame queue, then into the result register once free.
`include "radar_target_frame_parser_defines.svh"

module radar_target_frame_parser import rtfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        reading_valid_o,
  output logic        motion_seen_o,
  output logic [1:0]  target_total_o,
  output logic [1:0]  presence_kind_o,
  output logic [15:0] nearest_cm_o
);

  logic   byte_accept;
  logic   mid_push, mid_full, mid_empty, mid_pop;
  frame_t mid_in, mid_out;

  assign byte_accept = push && !mid_full;
  assign full        = mid_full;

  // parser front end
  rtfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_accept),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (mid_push),
    .frame_o       (mid_in)
  );

  // captured frame queue
  rtfp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_req_i  (mid_push),
    .push_data_i (mid_in),
    .full_o      (mid_full),
    .pop_req_i   (mid_pop),
    .empty_o     (mid_empty),
    .pop_data_o  (mid_out)
  );

  // reading back end
  rtfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_avail_i   (!mid_empty),
    .frame_i         (mid_out),
    .frame_take_o    (mid_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .reading_valid_o (reading_valid_o),
    .motion_seen_o   (motion_seen_o),
    .target_total_o  (target_total_o),
    .presence_kind_o (presence_kind_o),
    .nearest_cm_o    (nearest_cm_o)
  );

  // checks
  `RTFP_ASSERT_NOW(a_mid_no_overflow, mid_push, !mid_full)
  `RTFP_ASSERT_NOW(a_invalid_is_empty, !empty && !reading_valid_o,
                   target_total_o == 2'd0 && nearest_cm_o == 16'd0)
  `RTFP_ASSERT_NOW(a_kind_matches_motion, !empty && motion_seen_o,
                   presence_kind_o == PresMoving && target_total_o != 2'd0)
  `RTFP_ASSERT_NEXT(a_result_holds, !empty && !pop,
                    !empty && $stable(nearest_cm_o) && $stable(target_total_o))

endmodule

FILE: tb/tb_radar_target_frame_parser.sv
// testbench for the radar target frame parser: byte requests in, checked readings out
module tb_radar_target_frame_parser;
  import rtfp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseBytes  = 225;
  localparam int unsigned DrainCycles = 16;
  localparam logic [7:0] SyncSeq [4] = '{Sync0, Sync1, Sync2, Sync3};

  // one reading as it leaves the block
  typedef struct packed {
    logic        valid;
    logic        motion;
    logic [1:0]  total;
    logic [1:0]  kind;
    logic [15:0] near_cm;
  } reading_t;

  // frame tracker and store of readings still to come
  class reading_board;
    phase_e      phase;
    logic [1:0]  hdr_idx;
    logic [7:0]  len_lo;
    logic [6:0]  frame_len;
    logic [6:0]  pos;
    logic [7:0]  flags;
    logic [15:0] mv_cm;
    logic [15:0] st_cm;
    reading_t    pending[$];
    int unsigned errors;

    function new();
      phase     = PhHunt;
      hdr_idx   = 2'd0;
      len_lo    = 8'h00;
      frame_len = 7'd0;
      pos       = 7'd0;
      flags     = 8'h00;
      mv_cm     = 16'h0000;
      st_cm     = 16'h0000;
      errors    = 0;
    endfunction

    // reading built from the captured state byte and distances
    function reading_t decode_targets();
      reading_t r;
      r = '0;
      r.valid = 1'b1;
      r.kind  = PresNone;
      if (flags[0]) begin
        r.motion  = 1'b1;
        r.total   = 2'd1;
        r.kind    = PresMoving;
        r.near_cm = mv_cm;
      end
      if (flags[1]) begin
        r.total = r.total + 2'd1;
        if (!flags[0]) r.kind = PresStill;
        if (!flags[0] || st_cm < r.near_cm) r.near_cm = st_cm;
      end
      // upper bits alone make the reading invalid
      if (flags != 8'h00 && flags[1:0] == 2'b00) r.valid = 1'b0;
      return r;
    endfunction

    // advance the frame tracker by one accepted byte request
    function void note_byte(logic [7:0] b);
      logic [15:0] len;
      case (phase)
        PhHunt: begin
          // a byte that breaks the match is dropped, not retried
          if (b == SyncSeq[hdr_idx]) begin
            if (hdr_idx == 2'd3) begin
              hdr_idx = 2'd0;
              phase   = PhLenLo;
            end else begin
              hdr_idx = hdr_idx + 2'd1;
            end
          end else begin
            hdr_idx = 2'd0;
          end
        end
        PhLenLo: begin
          len_lo = b;
          phase  = PhLenHi;
        end
        PhLenHi: begin
          len = {b, len_lo};
          if (len < LenMin || len > LenMax) begin
            phase   = PhHunt;
            hdr_idx = 2'd0;
          end else begin
            frame_len = len[6:0];
            pos       = 7'd0;
            phase     = PhType;
          end
        end
        PhType: begin
          pos = 7'd1;
          if (b == TypeReport) phase = PhHeadOk;
          else phase = PhSkip;
        end
        PhHeadOk: begin
          pos = 7'd2;
          if (b == HeadReport) phase = PhReport;
          else phase = PhSkip;
        end
        PhSkip: begin
          pos = pos + 7'd1;
          if (pos >= frame_len + FrameExtra) begin
            phase   = PhHunt;
            hdr_idx = 2'd0;
          end
        end
        PhReport: begin
          // capture state byte and distances, energy and footer ignored
          case (pos)
            PosFlags:   flags = b;
            PosMoveLo:  mv_cm = {8'h00, b};
            PosMoveHi:  mv_cm = mv_cm | {b, 8'h00};
            PosStillLo: st_cm = {8'h00, b};
            PosStillHi: st_cm = st_cm | {b, 8'h00};
            default: ;
          endcase
          pos = pos + 7'd1;
          if (pos >= frame_len + FrameExtra) begin
            phase   = PhHunt;
            hdr_idx = 2'd0;
            pending.push_back(decode_targets());
          end
        end
        default: begin
          phase   = PhHunt;
          hdr_idx = 2'd0;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // compare one popped reading with the oldest one expected
    function void check_reading(reading_t got);
      reading_t want;
      if (pending.size() == 0) begin
        $error("reading popped with none expected: nearest_cm %0d", got.near_cm);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("reading_valid", 16'(want.valid), 16'(got.valid));
      compare_field("motion_seen", 16'(want.motion), 16'(got.motion));
      compare_field("target_total", 16'(want.total), 16'(got.total));
      compare_field("presence_kind", 16'(want.kind), 16'(got.kind));
      compare_field("nearest_cm", want.near_cm, got.near_cm);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        reading_valid;
  logic        motion_seen;
  logic [1:0]  target_total;
  logic [1:0]  presence_kind;
  logic [15:0] nearest_cm;

  int unsigned  cycle_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  reading_board board = new();

  radar_target_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte),
    .empty           (empty),
    .pop             (pop),
    .reading_valid_o (reading_valid),
    .motion_seen_o   (motion_seen),
    .target_total_o  (target_total),
    .presence_kind_o (presence_kind),
    .nearest_cm_o    (nearest_cm)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // reading consumer with random stalls
  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watch both request sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_byte(rx_byte);
      if (pop && !empty) begin
        board.check_reading({reading_valid, motion_seen, target_total, presence_kind,
                             nearest_cm});
      end
    end
  end

  // one byte request, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // header, length and body of one frame; bad lengths get a short tail only
  task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                            input logic [7:0] head, input logic [7:0] flags,
                            input logic [15:0] mv, input logic [15:0] st);
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    for (k = 0; k < 4; k++) send_byte(SyncSeq[k]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len < LenMin || len > LenMax) n = $urandom_range(0, 4);
    else n = 32'(len) + 32'(FrameExtra);
    for (k = 0; k < n; k++) begin
      case (k)
        0:          b = ftype;
        1:          b = head;
        PosFlags:   b = flags;
        PosMoveLo:  b = mv[7:0];
        PosMoveHi:  b = mv[15:8];
        PosStillLo: b = st[7:0];
        PosStillHi: b = st[15:8];
        default:    b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  // hold off requests until every expected reading has been popped
  task automatic wait_for_readings();
    push <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_cm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly well-formed report frames, with other frames, bad lengths and noise
  task automatic random_traffic(input int unsigned stop_at);
    int unsigned pick;
    int unsigned cnt;
    int unsigned k;
    logic [15:0] len;
    logic [15:0] mv;
    logic [15:0] st;
    logic [7:0]  flags;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(17, 64));
      else len = 16'($urandom_range(7, 16));
      flags = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) flags[7:2] = 6'd0;
      mv = random_cm();
      st = random_cm();
      if ($urandom_range(0, 9) == 0) st = mv;
      if (pick < 65) begin
        send_frame(len, TypeReport, HeadReport, flags, mv, st);
      end else if (pick < 75) begin
        // wrong type or wrong head, skipped whole
        if ($urandom_range(0, 1) == 0) begin
          send_frame(len, 8'($urandom_range(0, 255)), HeadReport, flags, mv, st);
        end else begin
          send_frame(len, TypeReport, 8'($urandom_range(0, 255)), flags, mv, st);
        end
      end else if (pick < 84) begin
        case ($urandom_range(0, 2))
          0: len = 16'($urandom_range(0, 6));
          1: len = 16'($urandom_range(65, 255));
          default: begin
            len[15:8] = 8'($urandom_range(1, 255));
            len[7:0]  = 8'($urandom_range(0, 255));
          end
        endcase
        send_frame(len, TypeReport, HeadReport, flags, mv, st);
      end else if (pick < 92) begin
        cnt = $urandom_range(1, 6);
        for (k = 0; k < cnt; k++) send_byte(8'($urandom_range(0, 255)));
      end else begin
        // header cut short by a stray byte
        cnt = $urandom_range(1, 3);
        for (k = 0; k < cnt; k++) send_byte(SyncSeq[k]);
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // distance and state byte extremes
    send_frame(16'd7, TypeReport, HeadReport, 8'h00, 16'h0000, 16'h0000);
    send_frame(16'd7, TypeReport, HeadReport, 8'h01, 16'hFFFF, 16'h0000);
    send_frame(16'd64, TypeReport, HeadReport, 8'h02, 16'h0000, 16'hFFFF);
    send_frame(16'd13, TypeReport, HeadReport, 8'h03, 16'd300, 16'd120);
    send_frame(16'd9, TypeReport, HeadReport, 8'h03, 16'd10, 16'd500);
    send_frame(16'd8, TypeReport, HeadReport, 8'h03, 16'd77, 16'd77);
    // upper state bits only, then all bits set
    send_frame(16'd7, TypeReport, HeadReport, 8'h04, 16'd5, 16'd6);
    send_frame(16'd7, TypeReport, HeadReport, 8'hFF, 16'd200, 16'd100);
    // lengths out of range
    send_frame(16'd6, TypeReport, HeadReport, 8'h01, 16'd1, 16'd2);
    send_frame(16'd65, TypeReport, HeadReport, 8'h01, 16'd1, 16'd2);
    send_frame(16'h0107, TypeReport, HeadReport, 8'h01, 16'd1, 16'd2);
    // non-report frames
    send_frame(16'd7, 8'h01, HeadReport, 8'h01, 16'd3, 16'd4);
    send_frame(16'd7, TypeReport, 8'h55, 8'h01, 16'd3, 16'd4);
    send_frame(16'd64, 8'hFF, 8'h00, 8'h02, 16'd3, 16'd4);
    // broken header then a clean frame, then a header whose break swallows the next F4
    send_byte(Sync0);
    send_byte(Sync1);
    send_byte(Sync0);
    send_frame(16'd7, TypeReport, HeadReport, 8'h02, 16'd9, 16'd8);
    send_byte(Sync0);
    send_byte(Sync1);
    send_frame(16'd7, TypeReport, HeadReport, 8'h01, 16'd9, 16'd8);
    wait_for_readings();

    // no idling
    random_traffic(bytes_sent + PhaseBytes);
    wait_for_readings();
    // sender mostly idle
    send_idle_pct = 73;
    random_traffic(bytes_sent + PhaseBytes);
    wait_for_readings();
    // receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    random_traffic(bytes_sent + PhaseBytes);
    wait_for_readings();
    // both sides idle now and then
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    random_traffic(bytes_sent + PhaseBytes);

    recv_stall_pct = 0;
    wait_for_readings();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/rtfp_pkg.sv
src/rtfp_front.sv
src/rtfp_fifo.sv
src/rtfp_back.sv
src/radar_target_frame_parser.sv
tb/tb_radar_target_frame_parser.sv
